// ===== hdl/u8dec_pkg.sv =====
// Package for the UTF-8 decoder: opcode, state and handshake struct types,
// byte-class constants and the lead-byte length and payload-mask functions.
// Depends on nothing; every other file of the block imports it.
package u8dec_pkg;

	// Byte classes and masks.
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_TAG    = 8'h80;
	localparam int unsigned HELD_DEPTH = 5;
	localparam int unsigned CP_W       = 31;

	// Lengths that a lead byte may announce.
	localparam logic [2:0] LEN_ONE   = 3'd1;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;
	localparam logic [2:0] LEN_FIVE  = 3'd5;
	localparam logic [2:0] LEN_SIX   = 3'd6;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_BREAK,
		S_FRESH,
		S_END
	} state_t;

	// Datapath operations.
	typedef enum logic [2:0] {
		DP_NOP,
		DP_RAW_IN,
		DP_LEAD_IN,
		DP_CONT_END,
		DP_CONT_ADD,
		DP_BREAK,
		DP_REPLAY,
		DP_FRESH_Q
	} dp_op_t;

	// Command from controller to datapath.
	typedef struct packed {
		dp_op_t op;
		logic   last;
		logic   done;
		logic   clear;
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic open;
		logic cont_in;
		logic lead_in;
		logic complete_in;
		logic lead_q;
		logic end_q;
		logic idx_last;
		logic out_free;
	} dp_stat_t;

	// Sequence length announced by a byte; one for anything that is not a lead.
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		case (b) inside
			[8'hC2:8'hDF]: len = LEN_TWO;
			[8'hE0:8'hEF]: len = LEN_THREE;
			[8'hF0:8'hF7]: len = LEN_FOUR;
			[8'hF8:8'hFB]: len = LEN_FIVE;
			[8'hFC:8'hFD]: len = LEN_SIX;
			default:       len = LEN_ONE;
		endcase
		return len;
	endfunction

	// Payload bits of a lead byte for a given sequence length.
	function automatic logic [7:0] lead_mask(input logic [2:0] len);
		logic [7:0] m;
		case (len)
			LEN_ONE:   m = 8'h7F;
			LEN_TWO:   m = 8'h1F;
			LEN_THREE: m = 8'h0F;
			LEN_FOUR:  m = 8'h07;
			LEN_FIVE:  m = 8'h03;
			LEN_SIX:   m = 8'h01;
			default:   m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

// ===== hdl/utf8_to_codepoint_decoder_top.sv =====
// UTF-8 decoder: takes one text byte per word and gives one code point per
// well-formed sequence, or raw byte values where a sequence is broken or cut
// short by the end of the text. A byte that completes a sequence or stands
// alone gives its word in the next cycle through the output register, so
// well-formed text runs at one byte per cycle while the output side keeps up.
// A byte that breaks an open sequence is accepted and latched; then each held
// byte is replayed through the single output register, and then the breaking
// byte is handled afresh. When the text ends inside a sequence, the held
// bytes are replayed. Besides the replay states, the output register is the
// only pacing element; a stalled output holds off new bytes.
// Depends on u8dec_pkg, u8dec_ctrl and u8dec_dp.
module utf8_to_codepoint_decoder_top
	import u8dec_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            text_end,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CP_W-1:0] code_point,
	output logic            run_last,
	output logic            text_done
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencing of accepts and replays.
	u8dec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.text_end (text_end),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Held bytes, accumulator and output word.
	u8dec_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_point (code_point),
		.run_last   (run_last),
		.text_done  (text_done)
	);

endmodule

// ===== hdl/u8dec_dp.sv =====
// Datapath of the UTF-8 decoder: held sequence bytes, payload accumulator,
// replay index, latched breaking byte and the registered output word.
// Depends on u8dec_pkg; driven by u8dec_ctrl through dp_cmd_t.
module u8dec_dp
	import u8dec_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [7:0]          in_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CP_W-1:0]     code_point,
	output logic                run_last,
	output logic                text_done
);

	logic [7:0]      held_q [HELD_DEPTH];
	logic [2:0]      held_count_q;
	logic [2:0]      seq_len_q;
	logic [CP_W-1:0] partial_q;
	logic [2:0]      idx_q;
	logic [7:0]      byte_q;
	logic            end_q;
	logic            out_valid_q;
	logic [CP_W-1:0] code_point_q;
	logic            run_last_q;
	logic            text_done_q;

	logic            out_free;
	logic [CP_W-1:0] partial_next;
	logic [7:0]      fresh_byte;
	logic [2:0]      fresh_len;
	logic            emit;
	logic [CP_W-1:0] emit_val;

	// Output slot is free when empty or being taken this cycle.
	assign out_free     = !out_valid_q || out_ready;
	assign partial_next = {partial_q[CP_W-7:0], in_byte[5:0]};
	assign fresh_byte   = (cmd.op == DP_FRESH_Q) ? byte_q : in_byte;
	assign fresh_len    = lead_len(fresh_byte);

	// Status toward the controller.
	always_comb begin
		stat.open        = (held_count_q != 3'd0);
		stat.cont_in     = ((in_byte & CONT_MASK) == CONT_TAG);
		stat.lead_in     = (lead_len(in_byte) != LEN_ONE);
		stat.complete_in = (({1'b0, held_count_q} + 4'd1) >= {1'b0, seq_len_q})
			|| (held_count_q >= 3'(HELD_DEPTH));
		stat.lead_q      = (lead_len(byte_q) != LEN_ONE);
		stat.end_q       = end_q;
		stat.idx_last    = (idx_q == (held_count_q - 3'd1));
		stat.out_free    = out_free;
	end

	// Which word, if any, goes to the output register.
	always_comb begin
		emit     = 1'b0;
		emit_val = '0;
		case (cmd.op)
			DP_RAW_IN: begin
				emit     = 1'b1;
				emit_val = {{(CP_W-8){1'b0}}, in_byte};
			end
			DP_CONT_END: begin
				emit     = 1'b1;
				emit_val = partial_next;
			end
			DP_REPLAY: begin
				emit     = 1'b1;
				emit_val = {{(CP_W-8){1'b0}}, held_q[idx_q]};
			end
			DP_FRESH_Q: begin
				emit     = !stat.lead_q;
				emit_val = {{(CP_W-8){1'b0}}, byte_q};
			end
			default: begin
				emit     = 1'b0;
				emit_val = '0;
			end
		endcase
	end

	// Sequence bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			seq_len_q    <= '0;
			partial_q    <= '0;
			idx_q        <= '0;
			end_q        <= 1'b0;
		end else begin
			case (cmd.op)
				DP_LEAD_IN: begin
					held_count_q <= 3'd1;
					seq_len_q    <= fresh_len;
					partial_q    <= {{(CP_W-8){1'b0}}, fresh_byte & lead_mask(fresh_len)};
				end
				DP_FRESH_Q: begin
					if (stat.lead_q) begin
						held_count_q <= 3'd1;
						seq_len_q    <= fresh_len;
						partial_q    <= {{(CP_W-8){1'b0}},
							fresh_byte & lead_mask(fresh_len)};
					end
				end
				DP_CONT_END: begin
					held_count_q <= '0;
					seq_len_q    <= '0;
					partial_q    <= '0;
				end
				DP_CONT_ADD: begin
					held_count_q <= held_count_q + 3'd1;
					partial_q    <= partial_next;
				end
				DP_BREAK: begin
					end_q <= cmd.done;
				end
				DP_REPLAY: begin
					if (cmd.clear) begin
						idx_q        <= '0;
						held_count_q <= '0;
						seq_len_q    <= '0;
						partial_q    <= '0;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Held bytes and the latched breaking byte.
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LEAD_IN:  held_q[0] <= in_byte;
			DP_FRESH_Q:  held_q[0] <= byte_q;
			DP_CONT_ADD: held_q[held_count_q] <= in_byte;
			DP_BREAK:    byte_q <= in_byte;
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			code_point_q <= emit_val;
			run_last_q   <= cmd.last;
			text_done_q  <= cmd.done;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = code_point_q;
	assign run_last   = run_last_q;
	assign text_done  = text_done_q;

`ifndef SYNTH
	// The hold never grows past five bytes.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= 3'(HELD_DEPTH))
		else $error("held byte count out of range");

	// An open sequence holds fewer bytes than its announced length.
	a_open_len: assert property (@(posedge clk) disable iff (!arst_n)
		(held_count_q != 3'd0) |-> (seq_len_q >= LEN_TWO && held_count_q < seq_len_q))
		else $error("open sequence inconsistent with its length");

	// A new word is only loaded into a free output slot.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("output word overwritten before it was taken");
`endif

endmodule

// ===== hdl/u8dec_ctrl.sv =====
// Controller of the UTF-8 decoder: accepts bytes and sequences the replay
// of broken or unfinished sequences one word per cycle while out_free.
// Depends on u8dec_pkg; commands u8dec_dp through dp_cmd_t.
module u8dec_ctrl
	import u8dec_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     text_end,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_next;
	logic   take;

	assign in_ready = (state_q == S_IDLE) && stat.out_free;
	assign take     = in_valid && in_ready;

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					if (!stat.open) begin
						if (stat.lead_in && text_end) begin
							state_next = S_END;
						end
					end else if (stat.cont_in) begin
						if (!stat.complete_in && text_end) begin
							state_next = S_END;
						end
					end else begin
						state_next = S_BREAK;
					end
				end
			end
			S_BREAK: begin
				if (stat.out_free && stat.idx_last) begin
					state_next = S_FRESH;
				end
			end
			S_FRESH: begin
				if (stat.out_free) begin
					state_next = (stat.lead_q && stat.end_q) ? S_END : S_IDLE;
				end
			end
			S_END: begin
				if (stat.out_free && stat.idx_last) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd.op    = DP_NOP;
		cmd.last  = 1'b0;
		cmd.done  = 1'b0;
		cmd.clear = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					if (!stat.open) begin
						if (stat.lead_in) begin
							cmd.op = DP_LEAD_IN;
						end else begin
							cmd.op   = DP_RAW_IN;
							cmd.last = 1'b1;
							cmd.done = text_end;
						end
					end else if (stat.cont_in) begin
						if (stat.complete_in) begin
							cmd.op   = DP_CONT_END;
							cmd.last = 1'b1;
							cmd.done = text_end;
						end else begin
							cmd.op = DP_CONT_ADD;
						end
					end else begin
						// Latch the breaking byte and its end flag.
						cmd.op   = DP_BREAK;
						cmd.done = text_end;
					end
				end
			end
			S_BREAK: begin
				if (stat.out_free) begin
					cmd.op    = DP_REPLAY;
					cmd.clear = stat.idx_last;
					cmd.last  = stat.idx_last && stat.lead_q && !stat.end_q;
				end
			end
			S_FRESH: begin
				if (stat.out_free) begin
					cmd.op   = DP_FRESH_Q;
					cmd.last = 1'b1;
					cmd.done = stat.end_q;
				end
			end
			S_END: begin
				if (stat.out_free) begin
					cmd.op    = DP_REPLAY;
					cmd.clear = stat.idx_last;
					cmd.last  = stat.idx_last;
					cmd.done  = stat.idx_last;
				end
			end
			default: begin
				cmd.op = DP_NOP;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

`ifndef SYNTH
	// Replay states only run while a sequence is held.
	a_replay_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BREAK || state_q == S_END) |-> stat.open)
		else $error("replay with no held sequence");

	// A breaking byte always leads into the replay of the held bytes.
	a_break_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_BREAK) |=> (state_q == S_BREAK))
		else $error("broken sequence not replayed");
`endif

endmodule
